// File: hw/rtl/tsq_pkg.sv
package tsq_pkg;

    // Default number of cells in the queue.
    localparam int DEPTH_DEF = 16;

    localparam int ID_W    = 8;
    localparam int STAMP_W = 16;
    localparam int SIZE_W  = 16;
    localparam int TOTAL_W = 20;
    localparam int OCC_W   = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SUM    = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Contents of one queue slot.
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
        logic [SIZE_W-1:0]  size;
    } t_slot;

    // Scan wavefront handed from cell to cell.
    typedef struct packed {
        logic               vld;
        logic               fnd;
        logic [TOTAL_W-1:0] acc;
    } t_wave;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic  ins_en;
        logic  del_en;
        t_slot key;
    } t_cmd;

endpackage

// File: hw/rtl/tsq_req_if.sv
interface tsq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  entry_id;
    logic [15:0] stamp;
    logic [15:0] entry_size;

    modport src (output valid, mode, entry_id, stamp, entry_size, input ready);
    modport snk (input valid, mode, entry_id, stamp, entry_size, output ready);
endinterface

// File: hw/rtl/tsq_rsp_if.sv
interface tsq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [19:0] size_total;
    logic [4:0]  occupancy;

    modport src (output valid, status, size_total, occupancy, input ready);
    modport snk (input valid, status, size_total, occupancy, output ready);
endinterface

// File: hw/rtl/timestamp_ordered_request_queue_top.sv
// Flow: an insert (or an unused mode) goes from idle straight to the finish state; a
// remove or a size query first waits in the scan state for the wavefront to cross all cells.
// One item at a time: the finish state waits until the response slot is free, registers the
// result and returns to idle, and only then is the next item taken.
// Reset (synchronous, active low) empties the queue and clears the handshake state;
// the slot contents are left as they are and are never read beyond the fill count.
module timestamp_ordered_request_queue_top
    import tsq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tsq_req_if.snk i_req,
    tsq_rsp_if.src o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    // The queue is a row of cells, cell 0 holding the head. The controller takes
    // one item, and for a remove or a query it launches a wavefront into cell 0.
    // The wavefront moves one cell per cycle, carrying the saturating size total of
    // the entries ahead of the first id match and a flag telling whether the match
    // was seen. Each cell remembers whether it sits at or after the match, so a
    // remove is then a single step in which every marked cell takes its right neighbor.
    // An insert needs no scan: the queue is always sorted, so each cell decides on
    // its own stamp compare whether it takes the new item, takes its left neighbor,
    // or holds, and all cells update together.

    t_cmd          w_cmd;
    t_wave         w_wave_in;
    logic [CW-1:0] w_count;
    t_slot         w_slot [DEPTH];
    logic          w_flag [DEPTH];
    t_wave         w_wave [DEPTH];

    tsq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_wave  (w_wave[DEPTH-1]),
        .o_wave  (w_wave_in),
        .o_cmd   (w_cmd),
        .o_count (w_count)
    );

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            t_slot left_slot;
            logic  left_flag;
            t_slot right_slot;
            t_wave wave_in;

            if (k == 0) begin : g_first
                // The head has no left neighbor; the wavefront comes from the controller.
                assign left_slot = w_cmd.key;
                assign left_flag = 1'b0;
                assign wave_in   = w_wave_in;
            end else begin : g_next
                assign left_slot = w_slot[k-1];
                assign left_flag = w_flag[k-1];
                assign wave_in   = w_wave[k-1];
            end

            if (k == DEPTH - 1) begin : g_last
                // Past the tail there is nothing to pull in; the slot keeps its value.
                assign right_slot = w_slot[k];
            end else begin : g_inner
                assign right_slot = w_slot[k+1];
            end

            tsq_cell #(
                .DEPTH (DEPTH),
                .IDX   (k)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_count     (w_count),
                .i_left      (left_slot),
                .i_left_flag (left_flag),
                .i_right     (right_slot),
                .i_wave      (wave_in),
                .o_slot      (w_slot[k]),
                .o_flag      (w_flag[k]),
                .o_wave      (w_wave[k])
            );
        end
    endgenerate

endmodule

// File: hw/rtl/tsq_cell.sv
module tsq_cell
    import tsq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [CW-1:0] i_count,
    input  t_slot         i_left,
    input  logic          i_left_flag,
    input  t_slot         i_right,
    input  t_wave         i_wave,
    output t_slot         o_slot,
    output logic          o_flag,
    output t_wave         o_wave
);

    t_slot  r_slot, n_slot;
    t_wave  r_wave, n_wave;
    logic   r_mark;
    logic   active;
    logic   match;
    logic   take_new;
    logic [TOTAL_W:0] sum;

    assign active = CW'(IDX) < i_count;
    assign match  = active && (r_slot.id == i_cmd.key.id);

    // Insert position flag: set at and after the place the new entry lands.
    // The head only yields to a strictly smaller stamp.
    generate
        if (IDX == 0) begin : g_head
            assign o_flag = (i_count == '0) || (i_cmd.key.stamp < r_slot.stamp);
        end else begin : g_body
            assign o_flag = !active || !(r_slot.stamp < i_cmd.key.stamp);
        end
    endgenerate

    assign take_new = o_flag && !i_left_flag;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins_en) begin
            if (take_new) begin
                n_slot = i_cmd.key;
            end else if (i_left_flag) begin
                n_slot = i_left;
            end
        end else if (i_cmd.del_en && r_mark) begin
            n_slot = i_right;
        end
    end

    assign sum = {1'b0, i_wave.acc} + {{(TOTAL_W + 1 - SIZE_W){1'b0}}, r_slot.size};

    always_comb begin
        n_wave     = i_wave;
        n_wave.fnd = i_wave.fnd || match;
        if (!(i_wave.fnd || match || !active)) begin
            n_wave.acc = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_wave.vld) begin
            r_mark <= n_wave.fnd;
        end
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_slot = r_slot;
    assign o_wave = r_wave;

endmodule

// File: hw/rtl/tsq_ctrl.sv
module tsq_ctrl
    import tsq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsq_req_if.snk        i_req,
    tsq_rsp_if.src        o_rsp,
    input  t_wave         i_wave,
    output t_wave         o_wave,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_count
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_mode;
    t_slot              r_key;
    logic               r_start;
    logic               r_found;
    logic [TOTAL_W-1:0] r_acc;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovalid;
    logic [1:0]         r_status, n_status;
    logic [TOTAL_W-1:0] r_total;
    logic [OCC_W-1:0]   r_occ;
    logic               accept;
    logic               can_out;
    logic               commit;
    logic               full;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign can_out     = !r_ovalid || o_rsp.ready;
    assign commit      = (r_state == ST_FINISH) && can_out;
    assign full        = (r_count == CW'(DEPTH));

    assign o_cmd.ins_en = commit && (r_mode == MODE_INSERT) && !full;
    assign o_cmd.del_en = commit && (r_mode == MODE_REMOVE) && r_found;
    assign o_cmd.key    = r_key;

    assign o_wave.vld = r_start;
    assign o_wave.fnd = 1'b0;
    assign o_wave.acc = '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.mode == MODE_REMOVE || i_req.mode == MODE_SUM) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (i_wave.vld) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (can_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_status = STAT_DONE;
        if (r_mode == MODE_INSERT) begin
            if (full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (r_mode == MODE_REMOVE) begin
            if (r_found) begin
                n_count = r_count - 1'b1;
            end else begin
                n_status = STAT_MISS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode         <= i_req.mode;
            r_key.id       <= i_req.entry_id;
            r_key.stamp    <= i_req.stamp;
            r_key.size     <= i_req.entry_size;
        end
        if (r_state == ST_SCAN && i_wave.vld) begin
            r_found <= i_wave.fnd;
            r_acc   <= i_wave.acc;
        end
        if (commit) begin
            r_status <= n_status;
            r_total  <= (r_mode == MODE_SUM) ? r_acc : '0;
            r_occ    <= OCC_W'(n_count);
        end
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept && (i_req.mode == MODE_REMOVE || i_req.mode == MODE_SUM);
            if (commit) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_status;
    assign o_rsp.size_total = r_total;
    assign o_rsp.occupancy  = r_occ;
    assign o_count          = r_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_wave_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wave.vld |-> r_state == ST_SCAN)
        else $error("scan wavefront returned outside scan");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ins_en |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the queue");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.del_en |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not shrink the queue");

endmodule
